### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, skipped while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/hrlc_pkg.sv
package hrlc_pkg;

    localparam int NUM_LEDS   = 25;
    localparam int NUM_STG    = 8;
    localparam int ONE_FX     = 65536;
    localparam int HALF_FX    = 32768;
    localparam int THIRD_TURN = 65536;
    localparam int TURN3      = 196608;
    localparam int SEG_SIXTH  = 32768;
    localparam int SEG_HALF   = 98304;
    localparam int SEG_2THIRD = 131072;
    localparam int BRIGHT_RST = 255;

    typedef logic [NUM_STG:1] t_stage_vec;

    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

### hw/rtl/hrlc_front.sv
module hrlc_front import hrlc_pkg::*; (
    input  logic        i_clk,
    input  t_stage_vec  i_en,
    input  logic [15:0] i_hue,
    input  logic [16:0] i_saturation,
    input  logic [16:0] i_lightness,
    output logic [17:0] o_t_red,
    output logic [17:0] o_t_green,
    output logic [17:0] o_t_blue,
    output logic [32:0] o_p,
    output logic [32:0] o_d
);

    logic [16:0] n_s1_sat, n_s1_light;
    logic [33:0] n_ls;
    logic [17:0] h3, t_red_raw, n_t_red, n_t_blue;
    logic [16:0] r_s1_sat, r_s1_light;
    logic [32:0] r_s1_ls;
    logic [17:0] r_s1_t_red, r_s1_t_green, r_s1_t_blue;

    logic [33:0] q_lo, q_hi;
    logic [32:0] n_q;
    logic [32:0] r_s2_q;
    logic [16:0] r_s2_light;

    logic [33:0] p_full, d_full;
    logic [32:0] r_s3_p, r_s3_d;

    // stage 1: clamp, product l*s, hue offsets
    assign n_s1_sat   = (i_saturation > 17'(ONE_FX)) ? 17'(ONE_FX) : i_saturation;
    assign n_s1_light = (i_lightness > 17'(ONE_FX)) ? 17'(ONE_FX) : i_lightness;
    assign n_ls       = n_s1_sat * n_s1_light;
    assign h3         = {1'b0, i_hue, 1'b0} + {2'b00, i_hue};
    assign t_red_raw  = h3 + 18'(THIRD_TURN);
    assign n_t_red    = (t_red_raw > 18'(TURN3)) ? t_red_raw - 18'(TURN3) : t_red_raw;
    assign n_t_blue   = (h3 < 18'(THIRD_TURN)) ? h3 + 18'(2 * THIRD_TURN)
                                               : h3 - 18'(THIRD_TURN);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_sat     <= n_s1_sat;
            r_s1_light   <= n_s1_light;
            r_s1_ls      <= n_ls[32:0];
            r_s1_t_red   <= n_t_red;
            r_s1_t_green <= h3;
            r_s1_t_blue  <= n_t_blue;
        end
    end

    // stage 2: q
    assign q_lo = {1'b0, r_s1_light, 16'h0000} + {1'b0, r_s1_ls};
    assign q_hi = {1'b0, r_s1_light, 16'h0000} + {1'b0, r_s1_sat, 16'h0000}
                - {1'b0, r_s1_ls};
    assign n_q  = (r_s1_light < 17'(HALF_FX)) ? q_lo[32:0] : q_hi[32:0];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_q     <= n_q;
            r_s2_light <= r_s1_light;
        end
    end

    // stage 3: p = 2l - q, d = q - p
    assign p_full = {r_s2_light, 17'h00000} - {1'b0, r_s2_q};
    assign d_full = {r_s2_q, 1'b0} - {r_s2_light, 17'h00000};

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_p <= p_full[32:0];
            r_s3_d <= d_full[32:0];
        end
    end

    assign o_t_red   = r_s1_t_red;
    assign o_t_green = r_s1_t_green;
    assign o_t_blue  = r_s1_t_blue;
    assign o_p       = r_s3_p;
    assign o_d       = r_s3_d;

endmodule

### hw/rtl/hrlc_chan.sv
module hrlc_chan import hrlc_pkg::*; (
    input  logic        i_clk,
    input  t_stage_vec  i_en,
    input  logic [17:0] i_t,
    input  logic [32:0] i_p,
    input  logic [32:0] i_d,
    output logic [7:0]  o_chan
);

    logic [17:0] t_fall;
    logic [15:0] n_u;
    logic [15:0] r_s2_u, r_s3_u;
    logic [48:0] n_prod;
    logic [47:0] r_s4_prod;
    logic [32:0] r_s4_p;
    logic [47:0] n_c;
    logic [47:0] r_s5_c;
    logic [55:0] n_x;
    logic [7:0]  n_chan;
    logic [7:0]  r_s6_chan;

    // stage 2: segment weight
    assign t_fall = 18'(SEG_2THIRD) - i_t;

    always_comb begin
        if (i_t < 18'(SEG_SIXTH)) begin
            n_u = i_t[15:0];
        end else if (i_t < 18'(SEG_HALF)) begin
            n_u = 16'(SEG_SIXTH);
        end else if (i_t < 18'(SEG_2THIRD)) begin
            n_u = t_fall[15:0];
        end else begin
            n_u = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_u <= n_u;
        end
        if (i_en[3]) begin
            r_s3_u <= r_s2_u;
        end
    end

    // stage 4: (q - p) * weight
    assign n_prod = i_d * r_s3_u;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_prod <= n_prod[47:0];
            r_s4_p    <= i_p;
        end
    end

    // stage 5: color value
    assign n_c = {r_s4_p, 15'h0000} + r_s4_prod;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s5_c <= n_c;
        end
    end

    // stage 6: scale to 0..255, round half up
    assign n_x    = {r_s5_c, 8'h00} - {8'h00, r_s5_c} + (56'd1 << 46);
    assign n_chan = n_x[55] ? 8'hFF : n_x[54:47];

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_s6_chan <= n_chan;
        end
    end

    assign o_chan = r_s6_chan;

endmodule

### hw/rtl/hrlc_scale.sv
module hrlc_scale import hrlc_pkg::*; (
    input  logic       i_clk,
    input  t_stage_vec i_en,
    input  logic [7:0] i_chan,
    input  logic [7:0] i_bright,
    input  logic       i_we,
    output logic [7:0] o_byte
);

    logic [15:0] n_sc;
    logic [15:0] r_s7_sc;
    logic [16:0] n_sum;
    logic [7:0]  n_byte;
    logic [7:0]  r_s8_byte;

    assign n_sc = i_chan * i_bright;

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_s7_sc <= n_sc;
        end
    end

    // floor(x / 255) for x = chan * bright, at most 255 * 255
    assign n_sum  = {1'b0, r_s7_sc} + {9'h000, r_s7_sc[15:8]} + 17'd1;
    assign n_byte = i_we ? flip_byte(n_sum[15:8]) : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_s8_byte <= n_byte;
        end
    end

    assign o_byte = r_s8_byte;

endmodule

### hw/rtl/hsl_to_rgb_led_color.sv
// channel | direction | handshake                 | payload
// in      | in        | i_in_valid / o_in_stall   | led_index, hue, saturation, lightness
// out     | out       | o_out_valid / i_out_stall | target_index, write_enable, red/green/blue
// cfg     | in        | i_cfg_valid / o_cfg_ready | brightness ceiling
//
// 8-stage pipeline, one item per cycle sustained while the output is not stalled
// depth set by the q/p arithmetic, the 33x16 segment multiply and the rounding adds
// synchronous active-low reset clears valid bits; the brightness ceiling resets to 255
// each stage holds while full and the stage after it is stalled; empty stages still fill
module hsl_to_rgb_led_color import hrlc_pkg::*; #(
    parameter int LED_COUNT = NUM_LEDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_led_index,
    input  logic [15:0] i_hue,
    input  logic [16:0] i_saturation,
    input  logic [16:0] i_lightness,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_target_index,
    output logic        o_write_enable,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

`include "assert_macros.svh"

    t_stage_vec  en;
    t_stage_vec  r_vld, n_vld;
    logic [7:0]  r_bright;
    logic [7:0]  r_idx [1:NUM_STG];
    logic        r_we  [1:NUM_STG];
    logic        n_we;

    logic [17:0] t_red, t_green, t_blue;
    logic [32:0] p_val, d_val;
    logic [7:0]  ch_red, ch_green, ch_blue;

    logic        out_dark;
    logic        idx_in_range;
    logic        out_held;

    // stage enables, from the output back
    always_comb begin
        en[NUM_STG] = ~r_vld[NUM_STG] | ~i_out_stall;
        for (int k = NUM_STG - 1; k >= 1; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[1]) begin
            n_vld[1] = i_in_valid;
        end
        for (int k = 2; k <= NUM_STG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= 8'(BRIGHT_RST);
        end else if (i_cfg_valid) begin
            r_bright <= i_cfg_data;
        end
    end

    assign n_we = {1'b0, i_led_index} < 9'(LED_COUNT);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_idx[1] <= i_led_index;
            r_we[1]  <= n_we;
        end
        for (int k = 2; k <= NUM_STG; k++) begin
            if (en[k]) begin
                r_idx[k] <= r_idx[k-1];
                r_we[k]  <= r_we[k-1];
            end
        end
    end

    hrlc_front u_front (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_t_red      (t_red),
        .o_t_green    (t_green),
        .o_t_blue     (t_blue),
        .o_p          (p_val),
        .o_d          (d_val)
    );

    hrlc_chan u_chan_red (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_t    (t_red),
        .i_p    (p_val),
        .i_d    (d_val),
        .o_chan (ch_red)
    );

    hrlc_chan u_chan_green (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_t    (t_green),
        .i_p    (p_val),
        .i_d    (d_val),
        .o_chan (ch_green)
    );

    hrlc_chan u_chan_blue (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_t    (t_blue),
        .i_p    (p_val),
        .i_d    (d_val),
        .o_chan (ch_blue)
    );

    hrlc_scale u_scale_red (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_chan   (ch_red),
        .i_bright (r_bright),
        .i_we     (r_we[NUM_STG-1]),
        .o_byte   (o_red)
    );

    hrlc_scale u_scale_green (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_chan   (ch_green),
        .i_bright (r_bright),
        .i_we     (r_we[NUM_STG-1]),
        .o_byte   (o_green)
    );

    hrlc_scale u_scale_blue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_chan   (ch_blue),
        .i_bright (r_bright),
        .i_we     (r_we[NUM_STG-1]),
        .o_byte   (o_blue)
    );

    assign o_in_stall     = ~en[1];
    assign o_out_valid    = r_vld[NUM_STG];
    assign o_target_index = r_idx[NUM_STG];
    assign o_write_enable = r_we[NUM_STG];
    assign o_cfg_ready    = 1'b1;

    assign out_dark     = (o_red == 8'h00) && (o_green == 8'h00) && (o_blue == 8'h00);
    assign idx_in_range = {1'b0, o_target_index} < 9'(LED_COUNT);
    assign out_held     = o_out_valid && i_out_stall;

    `ASSERT_SAME(a_off_is_dark, i_clk, i_rst_n, o_out_valid && !o_write_enable, out_dark)
    `ASSERT_SAME(a_we_in_range, i_clk, i_rst_n, o_out_valid && o_write_enable, idx_in_range)
    `ASSERT_SAME(a_full_stalls, i_clk, i_rst_n, (&r_vld) && i_out_stall, o_in_stall)
    `ASSERT_NEXT(a_held_stays, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_target_index))

endmodule

### test/hsl_to_rgb_led_color_check.sv
module hsl_to_rgb_led_color_check import hrlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_led_index,
    input  logic [15:0] i_hue,
    input  logic [16:0] i_saturation,
    input  logic [16:0] i_lightness,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_target_index,
    input  logic        i_write_enable,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] t_u64;

    typedef struct packed {
        logic [7:0] index;
        logic       we;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_led_color;

    t_led_color color_q[$];
    logic [7:0] brightness;

    // t is in units of 1/196608 of a turn, p and q in units of 2^-32
    function automatic logic [7:0] hue_segment_level(input t_u64 p, input t_u64 q,
                                                     input longint t);
        t_u64 c;
        if (t < 0) t += TURN3;
        if (t > TURN3) t -= TURN3;
        if (t < SEG_SIXTH)
            c = p * 32768 + (q - p) * t_u64'(t);
        else if (t < SEG_HALF)
            c = q * 32768;
        else if (t < SEG_2THIRD)
            c = p * 32768 + (q - p) * t_u64'(SEG_2THIRD - t);
        else
            c = p * 32768;
        c = (c * 255 + (t_u64'(1) << 46)) >> 47;
        return (c > 255) ? 8'hFF : c[7:0];
    endfunction

    function automatic logic [7:0] dim_and_reverse(input t_u64 level, input logic [7:0] bright);
        t_u64 v;
        logic [7:0] b8;
        v = (level * t_u64'(bright)) / 255;
        b8 = v[7:0];
        return {<<{b8}};
    endfunction

    function automatic t_led_color predict_led_color(input logic [7:0] idx,
                                                     input logic [15:0] hue,
                                                     input logic [16:0] sat,
                                                     input logic [16:0] lit,
                                                     input logic [7:0] bright);
        t_u64 s, l, q, p, r, g, b;
        longint t0;
        t_led_color res;
        s = (sat > ONE_FX) ? t_u64'(ONE_FX) : t_u64'(sat);
        l = (lit > ONE_FX) ? t_u64'(ONE_FX) : t_u64'(lit);
        if (s == 0) begin
            r = (l * 255 + 32768) >> 16;
            g = r;
            b = r;
        end else begin
            if (l < HALF_FX)
                q = l * (ONE_FX + s);
            else
                q = (l << 16) + (s << 16) - l * s;
            p = (l << 17) - q;
            t0 = 3 * longint'(hue);
            r = hue_segment_level(p, q, t0 + THIRD_TURN);
            g = hue_segment_level(p, q, t0);
            b = hue_segment_level(p, q, t0 - THIRD_TURN);
        end
        res.index = idx;
        res.we    = (idx < NUM_LEDS);
        res.red   = res.we ? dim_and_reverse(r, bright) : 8'd0;
        res.green = res.we ? dim_and_reverse(g, bright) : 8'd0;
        res.blue  = res.we ? dim_and_reverse(b, bright) : 8'd0;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
        brightness = BRIGHT_RST;
    end

    always @(posedge i_clk) begin
        t_led_color want;
        if (!i_rst_n) begin
            brightness = BRIGHT_RST;
            color_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                brightness = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                color_q.push_back(predict_led_color(i_led_index, i_hue, i_saturation,
                                                    i_lightness, brightness));
            if (i_out_valid && !i_out_stall) begin
                if (color_q.size() == 0) begin
                    $display("%0t: unexpected item, actual index %0d", $time, i_target_index);
                    o_fail_count++;
                end else begin
                    want = color_q.pop_front();
                    check_field("target_index", want.index, i_target_index);
                    check_field("write_enable", want.we, i_write_enable);
                    check_field("red", want.red, i_red);
                    check_field("green", want.green, i_green);
                    check_field("blue", want.blue, i_blue);
                    o_checked++;
                end
            end
        end
        o_pending = color_q.size();
    end

endmodule

### test/hsl_to_rgb_led_color_test.sv
module hsl_to_rgb_led_color_test;
    import hrlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 200;
    localparam int ITEMS_PER_SET  = 325;
    localparam int DRAIN_CYCLES   = 16;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  led_index;
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [16:0] lightness;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  target_index;
    logic        write_enable;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int fail_count;
    int pending;
    int checked;
    int items_sent;
    int idle_cycles;
    int no_gap_run;
    bit hold_done;

    hsl_to_rgb_led_color u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_led_index    (led_index),
        .i_hue          (hue),
        .i_saturation   (saturation),
        .i_lightness    (lightness),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_target_index (target_index),
        .o_write_enable (write_enable),
        .o_red          (red),
        .o_green        (green),
        .o_blue         (blue),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    hsl_to_rgb_led_color_check u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_led_index    (led_index),
        .i_hue          (hue),
        .i_saturation   (saturation),
        .i_lightness    (lightness),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_target_index (target_index),
        .i_write_enable (write_enable),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial clk = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gap_run > 0) begin
            no_gap_run--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            no_gap_run = 40;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic put_pixel(input logic [7:0] idx, input logic [15:0] h,
                             input logic [16:0] s, input logic [16:0] l, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        led_index  <= idx;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic write_brightness(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_random_pixel();
        logic [7:0]  idx;
        logic [15:0] h;
        logic [16:0] s;
        logic [16:0] l;
        int          r;
        int          hb;
        idx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, NUM_LEDS - 1))
                                          : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) begin
            // near a segment bound
            hb = $urandom_range(0, 6) * 65535 / 6 + $urandom_range(0, 4) - 2;
            if (hb < 0) hb = 0;
            if (hb > 65535) hb = 65535;
            h = 16'(hb);
        end else begin
            h = 16'($urandom_range(0, 65535));
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            s = 17'd0;
        else if (r == 1)
            s = 17'($urandom_range(ONE_FX + 1, 131071));
        else if (r == 2)
            s = 17'(ONE_FX);
        else
            s = 17'($urandom_range(1, ONE_FX));
        r = $urandom_range(0, 9);
        if (r == 0)
            l = 17'd0;
        else if (r == 1)
            l = 17'($urandom_range(ONE_FX + 1, 131071));
        else if (r == 2)
            l = 17'(ONE_FX);
        else if (r == 3)
            l = 17'($urandom_range(HALF_FX - 1, HALF_FX));
        else
            l = 17'($urandom_range(0, ONE_FX));
        put_pixel(idx, h, s, l, pick_gap());
    endtask

    // receiver stalls, with one long hold so the pipeline backs up
    initial begin
        int r;
        out_stall = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            if (!hold_done && items_sent >= 600) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 19);
                if (r < 8) begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end else if (r < 18) begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d items still pending", $time, pending);
            $display("** hsl_to_rgb_led_color: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [7:0] settings[6];
        settings = '{8'd255, 8'd0, 8'd1, 8'd128, 8'($urandom_range(2, 254)), 8'd255};
        idle_cycles = 0;
        items_sent  = 0;
        no_gap_run  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        led_index   = '0;
        hue         = '0;
        saturation  = '0;
        lightness   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 6; k++) begin
            write_brightness(settings[k]);
            if (k == 0) begin
                put_pixel(8'd0,   16'd0,     17'd0,      17'd0,      0);
                put_pixel(8'd24,  16'd65535, 17'd131071, 17'd131071, 0);
                put_pixel(8'd25,  16'd21845, 17'd65536,  17'd32768,  0);
                put_pixel(8'd255, 16'd43690, 17'd65536,  17'd32768,  1);
                put_pixel(8'd1,   16'd0,     17'd65536,  17'd32768,  0);
                put_pixel(8'd2,   16'd10922, 17'd65536,  17'd32768,  0);
                put_pixel(8'd3,   16'd10923, 17'd65536,  17'd32768,  0);
                put_pixel(8'd4,   16'd32768, 17'd65536,  17'd32768,  2);
                put_pixel(8'd5,   16'd43691, 17'd65536,  17'd32768,  0);
                put_pixel(8'd6,   16'd54613, 17'd65536,  17'd32768,  0);
                put_pixel(8'd7,   16'd30000, 17'd0,      17'd65536,  0);
                put_pixel(8'd8,   16'd30000, 17'd0,      17'd131071, 0);
                put_pixel(8'd9,   16'd12345, 17'd1,      17'd32767,  0);
                put_pixel(8'd10,  16'd12345, 17'd65537,  17'd32767,  3);
                put_pixel(8'd11,  16'd50000, 17'd131071, 17'd1,      0);
                put_pixel(8'd12,  16'd50000, 17'd40000,  17'd65536,  0);
                put_pixel(8'd13,  16'd65535, 17'd65536,  17'd65537,  0);
                put_pixel(8'd14,  16'd1,     17'd65535,  17'd49152,  0);
                put_pixel(8'd15,  16'd21846, 17'd20000,  17'd16384,  0);
                put_pixel(8'd170, 16'd43520, 17'd87381,  17'd87381,  0);
                put_pixel(8'd85,  16'd21930, 17'd43690,  17'd43690,  0);
            end
            for (int n = 0; n < ITEMS_PER_SET; n++)
                put_random_pixel();
            drain();
        end

        $display("stimulus: %0d pixel items over 6 brightness settings (0, 1, 128, 255 and one random)",
                 items_sent);
        $display("results: %0d compared, with random gaps, stalls and one long output hold",
                 checked);
        if (fail_count == 0)
            $display("** hsl_to_rgb_led_color: PASSED **");
        else
            $display("** hsl_to_rgb_led_color: FAILED **");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hrlc_pkg.sv
hw/rtl/hrlc_front.sv
hw/rtl/hrlc_chan.sv
hw/rtl/hrlc_scale.sv
hw/rtl/hsl_to_rgb_led_color.sv
test/hsl_to_rgb_led_color_check.sv
test/hsl_to_rgb_led_color_test.sv
